// ----- sv/ucd_pkg.sv -----
`timescale 1ns / 1ps
package ucd_pkg;
  localparam int unsigned MaxNodes = 256;
  localparam int unsigned MaxEdges = 1024;
  localparam int unsigned HalfCap  = 2 * MaxEdges;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned LinkW    = $clog2(HalfCap) + 1;
  localparam int unsigned AddrW    = $clog2(HalfCap);
  localparam int unsigned CountW   = NodeW + 1;

  typedef logic [NodeW-1:0] node_t;
  typedef logic [LinkW-1:0] link_t;

  localparam link_t NoLink = '1;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadNode = 2'd1,
    StFull    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SInit,
    SIdle,
    SClear,
    SAddA,
    SAddB,
    SAddC,
    SAddD,
    SScan,
    SScanChk,
    SRead,
    SLink,
    SNbr,
    SEval,
    SDone
  } state_e;

  typedef enum logic [4:0] {
    OpNone,
    OpInitStep,
    OpClrStep,
    OpLoad,
    OpReject,
    OpAddRdA,
    OpAddWrA,
    OpAddRdB,
    OpAddWrB,
    OpScanRd,
    OpScanNext,
    OpRoot,
    OpTopRd,
    OpPop,
    OpLinkRd,
    OpNbrRd,
    OpPushNbr,
    OpHit
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic add_bad;
    logic add_full;
    logic scan_end;
    logic seen;
    logic stack_empty;
    logic cursor_end;
    logic not_parent;
  } stat_t;
endpackage

// ----- sv/undirected_cycle_detect.sv -----
`timescale 1ns / 1ps
// Undirected cycle detector. After reset the block marks every adjacency list
// empty, with busy high. A stored edge passes through SAddA, SAddB, SAddC and
// SAddD before its result shows on done_o in SDone; a rejected edge goes from
// SAddA straight to SDone. A check first clears the visited map in SClear,
// then visits SScan and SScanChk per node scanned, SLink, SNbr and SEval per
// half-edge followed and SLink and SRead per frame popped, before SDone; these
// steps wait on registered reads of memories with separate read and write
// ports. Each result is shown for one cycle on done_o and cannot be held off.
module undirected_cycle_detect (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       command_i,
  input  logic [7:0] end_a_i,
  input  logic [7:0] end_b_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic       cycle_found_o
);
  ucd_pkg::cmd_t  cmd;
  ucd_pkg::stat_t stat;
  logic [8:0]     node_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) node_count_q <= 9'd256;
    else if (cfg_we_i) node_count_q <= cfg_wdata_i;
  end

  ucd_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .command_i, .stat_i(stat), .cmd_o(cmd), .busy, .done_o
  );

  ucd_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .node_count_i(node_count_q),
    .end_a_i, .end_b_i, .stat_o(stat), .status_o, .cycle_found_o
  );

`ifndef ASSERT_OFF
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("start not taken");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done while idle");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_add_nocycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ucd_pkg::StOk |-> !cycle_found_o) else $error("bad flags");
`endif
endmodule

// ----- sv/ucd_ctrl.sv -----
`timescale 1ns / 1ps
module ucd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           command_i,
  input  ucd_pkg::stat_t stat_i,
  output ucd_pkg::cmd_t  cmd_o,
  output logic           busy,
  output logic           done_o
);
  ucd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ucd_pkg::SInit;
    else state_q <= state_d;
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = ucd_pkg::OpNone;
    busy      = 1'b1;
    done_o    = 1'b0;
    case (state_q)
      ucd_pkg::SInit: begin
        cmd_o.op = ucd_pkg::OpInitStep;
        if (stat_i.clear_done) state_d = ucd_pkg::SIdle;
      end
      ucd_pkg::SIdle: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.op = ucd_pkg::OpLoad;
          if (command_i) state_d = ucd_pkg::SClear;
          else state_d = ucd_pkg::SAddA;
        end
      end
      ucd_pkg::SClear: begin
        cmd_o.op = ucd_pkg::OpClrStep;
        if (stat_i.clear_done) state_d = ucd_pkg::SScan;
      end
      ucd_pkg::SAddA: begin
        if (stat_i.add_bad || stat_i.add_full) begin
          cmd_o.op = ucd_pkg::OpReject;
          state_d  = ucd_pkg::SDone;
        end else begin
          cmd_o.op = ucd_pkg::OpAddRdA;
          state_d  = ucd_pkg::SAddB;
        end
      end
      ucd_pkg::SAddB: begin
        cmd_o.op = ucd_pkg::OpAddWrA;
        state_d  = ucd_pkg::SAddC;
      end
      ucd_pkg::SAddC: begin
        cmd_o.op = ucd_pkg::OpAddRdB;
        state_d  = ucd_pkg::SAddD;
      end
      ucd_pkg::SAddD: begin
        cmd_o.op = ucd_pkg::OpAddWrB;
        state_d  = ucd_pkg::SDone;
      end
      ucd_pkg::SScan: begin
        if (stat_i.scan_end) begin
          state_d = ucd_pkg::SDone;
        end else begin
          cmd_o.op = ucd_pkg::OpScanRd;
          state_d  = ucd_pkg::SScanChk;
        end
      end
      ucd_pkg::SScanChk: begin
        if (stat_i.seen) begin
          cmd_o.op = ucd_pkg::OpScanNext;
          state_d  = ucd_pkg::SScan;
        end else begin
          cmd_o.op = ucd_pkg::OpRoot;
          state_d  = ucd_pkg::SLink;
        end
      end
      ucd_pkg::SRead: begin
        if (stat_i.stack_empty) begin
          state_d = ucd_pkg::SScan;
        end else begin
          cmd_o.op = ucd_pkg::OpTopRd;
          state_d  = ucd_pkg::SLink;
        end
      end
      ucd_pkg::SLink: begin
        if (stat_i.cursor_end) begin
          cmd_o.op = ucd_pkg::OpPop;
          state_d  = ucd_pkg::SRead;
        end else begin
          cmd_o.op = ucd_pkg::OpLinkRd;
          state_d  = ucd_pkg::SNbr;
        end
      end
      ucd_pkg::SNbr: begin
        cmd_o.op = ucd_pkg::OpNbrRd;
        state_d  = ucd_pkg::SEval;
      end
      ucd_pkg::SEval: begin
        if (!stat_i.seen) begin
          cmd_o.op = ucd_pkg::OpPushNbr;
          state_d  = ucd_pkg::SLink;
        end else if (stat_i.not_parent) begin
          cmd_o.op = ucd_pkg::OpHit;
          state_d  = ucd_pkg::SDone;
        end else begin
          state_d = ucd_pkg::SLink;
        end
      end
      ucd_pkg::SDone: begin
        done_o  = 1'b1;
        state_d = ucd_pkg::SIdle;
      end
      default: state_d = ucd_pkg::SIdle;
    endcase
  end
endmodule

// ----- sv/ucd_dp.sv -----
`timescale 1ns / 1ps
module ucd_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ucd_pkg::cmd_t              cmd_i,
  input  logic [ucd_pkg::CountW-1:0] node_count_i,
  input  ucd_pkg::node_t             end_a_i,
  input  ucd_pkg::node_t             end_b_i,
  output ucd_pkg::stat_t             stat_o,
  output logic [1:0]                 status_o,
  output logic                       cycle_found_o
);
  typedef struct packed {
    ucd_pkg::node_t node;
    ucd_pkg::node_t parent;
    logic           has_parent;
    ucd_pkg::link_t cursor;
  } frame_t;

  ucd_pkg::link_t  head_mem [ucd_pkg::MaxNodes];
  ucd_pkg::link_t  next_mem [ucd_pkg::HalfCap];
  ucd_pkg::node_t  tgt_mem  [ucd_pkg::HalfCap];
  logic            vis_mem  [ucd_pkg::MaxNodes];
  frame_t          stk_mem  [ucd_pkg::MaxNodes];

  ucd_pkg::link_t             half_q;
  logic [ucd_pkg::CountW-1:0] top_q, scan_q;
  ucd_pkg::node_t             clr_q;
  logic                       cyc_q;
  ucd_pkg::node_t             a_q, b_q;
  ucd_pkg::status_e           st_q;
  frame_t                     fr_q;
  ucd_pkg::link_t             nxt_q;
  ucd_pkg::node_t             nb_q;
  ucd_pkg::link_t             head_rd_q;
  logic                       vis_rd_q;
  logic [ucd_pkg::CountW-1:0] live, top_m1;
  ucd_pkg::node_t             scan_node;

  logic           head_we, head_re;
  ucd_pkg::node_t head_wa, head_ra;
  ucd_pkg::link_t head_wd;
  logic           vis_we, vis_re, vis_wd;
  ucd_pkg::node_t vis_wa, vis_ra;
  logic           link_we;
  ucd_pkg::node_t link_tgt;
  logic           stk_we;
  ucd_pkg::node_t stk_wa;
  frame_t         stk_wd;

  assign live = (node_count_i > ucd_pkg::CountW'(ucd_pkg::MaxNodes))
              ? ucd_pkg::CountW'(ucd_pkg::MaxNodes) : node_count_i;
  assign top_m1    = top_q - ucd_pkg::CountW'(1);
  assign scan_node = scan_q[ucd_pkg::NodeW-1:0];

  assign stat_o.clear_done  = clr_q == '1;
  assign stat_o.add_bad     = ({1'b0, a_q} >= live) || ({1'b0, b_q} >= live);
  assign stat_o.add_full    = half_q > ucd_pkg::LinkW'(ucd_pkg::HalfCap - 2);
  assign stat_o.scan_end    = scan_q >= live;
  assign stat_o.seen        = vis_rd_q;
  assign stat_o.stack_empty = top_q == '0;
  assign stat_o.cursor_end  = fr_q.cursor >= half_q;
  assign stat_o.not_parent  = !(fr_q.has_parent && nb_q == fr_q.parent);
  assign status_o           = st_q;
  assign cycle_found_o      = cyc_q;

  always_comb begin
    head_we           = 1'b0;
    head_re           = 1'b0;
    head_wa           = clr_q;
    head_ra           = a_q;
    head_wd           = ucd_pkg::NoLink;
    vis_we            = 1'b0;
    vis_re            = 1'b0;
    vis_wa            = clr_q;
    vis_ra            = scan_node;
    vis_wd            = 1'b0;
    link_we           = 1'b0;
    link_tgt          = b_q;
    stk_we            = 1'b0;
    stk_wa            = top_q[ucd_pkg::NodeW-1:0];
    stk_wd.node       = scan_node;
    stk_wd.parent     = '0;
    stk_wd.has_parent = 1'b0;
    stk_wd.cursor     = head_rd_q;
    case (cmd_i.op)
      ucd_pkg::OpInitStep: head_we = 1'b1;
      ucd_pkg::OpClrStep: vis_we = 1'b1;
      ucd_pkg::OpAddRdA: head_re = 1'b1;
      ucd_pkg::OpAddWrA: begin
        head_we = 1'b1;
        head_wa = a_q;
        head_wd = half_q;
        link_we = 1'b1;
      end
      ucd_pkg::OpAddRdB: begin
        head_re = 1'b1;
        head_ra = b_q;
      end
      ucd_pkg::OpAddWrB: begin
        head_we  = 1'b1;
        head_wa  = b_q;
        head_wd  = half_q;
        link_we  = 1'b1;
        link_tgt = a_q;
      end
      ucd_pkg::OpScanRd: begin
        head_re = 1'b1;
        head_ra = scan_node;
        vis_re  = 1'b1;
      end
      ucd_pkg::OpRoot: begin
        vis_we = 1'b1;
        vis_wa = scan_node;
        vis_wd = 1'b1;
        stk_we = 1'b1;
      end
      ucd_pkg::OpNbrRd: begin
        head_re           = 1'b1;
        head_ra           = nb_q;
        vis_re            = 1'b1;
        vis_ra            = nb_q;
        stk_we            = 1'b1;
        stk_wa            = top_m1[ucd_pkg::NodeW-1:0];
        stk_wd.node       = fr_q.node;
        stk_wd.parent     = fr_q.parent;
        stk_wd.has_parent = fr_q.has_parent;
        stk_wd.cursor     = nxt_q;
      end
      ucd_pkg::OpPushNbr: begin
        vis_we            = 1'b1;
        vis_wa            = nb_q;
        vis_wd            = 1'b1;
        stk_we            = 1'b1;
        stk_wd.node       = nb_q;
        stk_wd.parent     = fr_q.node;
        stk_wd.has_parent = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (vis_re) vis_rd_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      tgt_mem[half_q[ucd_pkg::AddrW-1:0]]  <= link_tgt;
      next_mem[half_q[ucd_pkg::AddrW-1:0]] <= head_rd_q;
    end
    if (cmd_i.op == ucd_pkg::OpLinkRd) begin
      nxt_q <= next_mem[fr_q.cursor[ucd_pkg::AddrW-1:0]];
      nb_q  <= tgt_mem[fr_q.cursor[ucd_pkg::AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (cmd_i.op == ucd_pkg::OpTopRd) fr_q <= stk_mem[top_m1[ucd_pkg::NodeW-1:0]];
    else if (stk_we) fr_q <= stk_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= '0;
      top_q  <= '0;
      scan_q <= '0;
      clr_q  <= '0;
      cyc_q  <= 1'b0;
      st_q   <= ucd_pkg::StOk;
      a_q    <= '0;
      b_q    <= '0;
    end else begin
      case (cmd_i.op)
        ucd_pkg::OpInitStep: clr_q <= clr_q + ucd_pkg::NodeW'(1);
        ucd_pkg::OpClrStep: begin
          clr_q  <= clr_q + ucd_pkg::NodeW'(1);
          top_q  <= '0;
          scan_q <= '0;
        end
        ucd_pkg::OpLoad: begin
          a_q   <= end_a_i;
          b_q   <= end_b_i;
          st_q  <= ucd_pkg::StOk;
          cyc_q <= 1'b0;
        end
        ucd_pkg::OpReject: st_q <= stat_o.add_bad ? ucd_pkg::StBadNode : ucd_pkg::StFull;
        ucd_pkg::OpAddWrA: half_q <= half_q + ucd_pkg::LinkW'(1);
        ucd_pkg::OpAddWrB: half_q <= half_q + ucd_pkg::LinkW'(1);
        ucd_pkg::OpScanNext: scan_q <= scan_q + ucd_pkg::CountW'(1);
        ucd_pkg::OpRoot: begin
          scan_q <= scan_q + ucd_pkg::CountW'(1);
          top_q  <= top_q + ucd_pkg::CountW'(1);
        end
        ucd_pkg::OpPop: top_q <= top_m1;
        ucd_pkg::OpPushNbr: top_q <= top_q + ucd_pkg::CountW'(1);
        ucd_pkg::OpHit: cyc_q <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
